// ----- rtl/dfm_pkg.sv -----
package dfm_pkg;

    localparam int BUFFER_BYTES_DEF    = 1024;
    localparam int MAX_FRAME_BYTES_DEF = 64;
    localparam int FRAME_SLOTS_DEF     = 256;

    localparam int OP_W     = 2;
    localparam int DATA_W   = 8;
    localparam int FLEN_W   = 8;
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 3;
    localparam int PFR_W    = 9;
    localparam int PBY_W    = 11;
    localparam int MAXF_W   = 7;
    localparam int CAP_W    = 11;
    localparam int CFG_W    = 11;
    localparam int IDX_W    = 1;

    typedef enum logic [OP_W-1:0] {
        OP_SEND    = 2'd0,
        OP_RECEIVE = 2'd1,
        OP_CLOSE   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_FULL   = 3'd2,
        ST_CLOSED = 3'd3,
        ST_LARGE  = 3'd4
    } status_t;

    localparam logic [IDX_W-1:0] REG_MAX_FRAME = 1'd0;
    localparam logic [IDX_W-1:0] REG_CAPACITY  = 1'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RX_LEN,
        S_RX_STREAM
    } state_t;

endpackage

// ----- rtl/duplex_frame_mailbox.sv -----
// Duplex frame mailbox: one frame queue per direction, accounted in bytes.
// Command channel: an item (op, endpoint, first_of_frame, frame_length, data)
// is taken on a clock edge with start high and busy low.
// Results appear on the result ports for one cycle, marked by done; the
// receiver cannot stall, so every result is taken as it is shown.
// Send and close items: one result, done in the cycle after the item; busy stays
// low, so sends stream one byte per cycle into the byte memory.
// Receive: busy rises for the frame. With nothing queued one result appears
// the next cycle. Otherwise the frame length is taken from the length queue
// in S_RX_LEN, then bytes stream from the byte memory one per cycle, the last
// marked by last, and the next item can start on the edge that takes the last
// result (a zero-length frame gives one result, marked by last).
// Byte and length stores are synchronous memories with registered reads; their
// contents are undefined after reset and only written entries are read.
// Reset clears pointers, counts and send tracking, sets both open flags and
// sets config to max_frame 64 and capacity_bytes 1024; no clearing pass is needed.
// Configuration: write at any edge with cfg_we high, cfg_index selecting the
// register; no read-back.
module duplex_frame_mailbox
    import dfm_pkg::*;
#(
    parameter int BUFFER_BYTES    = BUFFER_BYTES_DEF,
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int FRAME_SLOTS     = FRAME_SLOTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     op,
    input  logic                endpoint,
    input  logic                first_of_frame,
    input  logic [FLEN_W-1:0]   frame_length,
    input  logic [DATA_W-1:0]   data,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [DATA_W-1:0]   rx_data,
    output logic [LEN_W-1:0]    rx_length,
    output logic                last,
    output logic [PFR_W-1:0]    pending_frames,
    output logic [PBY_W-1:0]    pending_bytes,
    output logic                channel_open
);

    localparam int BA_W = $clog2(BUFFER_BYTES);
    localparam int SA_W = $clog2(FRAME_SLOTS);
    localparam int BC_W = $clog2(BUFFER_BYTES + 1);
    localparam int SC_W = $clog2(FRAME_SLOTS + 1);
    localparam int W_W  = BC_W + 1;

    logic [DATA_W-1:0] bmem0 [BUFFER_BYTES];
    logic [DATA_W-1:0] bmem1 [BUFFER_BYTES];
    logic [LEN_W-1:0]  lmem0 [FRAME_SLOTS];
    logic [LEN_W-1:0]  lmem1 [FRAME_SLOTS];

    logic [BA_W-1:0] bhead_reg [2];
    logic [BC_W-1:0] bcnt_reg  [2];
    logic [SA_W-1:0] shead_reg [2];
    logic [SC_W-1:0] scnt_reg  [2];
    logic [1:0]      open_reg;
    logic [MAXF_W-1:0] maxf_reg;
    logic [CAP_W-1:0]  cap_reg;

    logic              tx_act_reg;
    logic              tx_end_reg;
    logic [FLEN_W-1:0] tx_len_reg;
    logic [FLEN_W-1:0] tx_done_reg;
    logic [STATUS_W-1:0] tx_ref_reg;

    state_t state_reg, state_next;
    logic              rx_dir_reg;
    logic [LEN_W-1:0]  rx_len_reg;
    logic [LEN_W-1:0]  rx_cnt_reg;
    logic [BA_W-1:0]   rx_ptr_reg;

    logic [DATA_W-1:0] brd0_reg, brd1_reg;
    logic [LEN_W-1:0]  lrd0_reg, lrd1_reg;

    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [DATA_W-1:0]   rxd_reg;
    logic [LEN_W-1:0]    rxl_reg;
    logic                last_reg;
    logic                pdir_reg;
    logic                rxsel_reg;

    logic accept;
    logic both_open;
    logic [W_W-1:0] eff_cap, eff_max;

    // send decode
    logic                s_wr, s_commit;
    logic [STATUS_W-1:0] s_status;
    logic [LEN_W-1:0]    s_clen;
    logic                s_dir;
    logic [BA_W-1:0]     s_waddr;

    // receive decode
    logic            r_dir;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] l_raw;

    assign accept    = start && !busy;
    assign both_open = open_reg[0] && open_reg[1];
    assign eff_cap   = (W_W'(cap_reg) < W_W'(BUFFER_BYTES)) ? W_W'(cap_reg)
                                                            : W_W'(BUFFER_BYTES);
    assign eff_max   = (W_W'(maxf_reg) < W_W'(MAX_FRAME_BYTES)) ? W_W'(maxf_reg)
                                                               : W_W'(MAX_FRAME_BYTES);
    assign busy      = (state_reg != S_IDLE);

    always_comb
    begin
        logic [W_W-1:0] need;
        logic [FLEN_W-1:0] dn;
        logic [W_W-1:0] off;
        s_wr     = 1'b0;
        s_commit = 1'b0;
        s_status = ST_OK;
        s_clen   = '0;
        s_dir    = endpoint;
        need     = W_W'(bcnt_reg[endpoint]) + W_W'(frame_length);
        dn       = first_of_frame ? '0 : tx_done_reg;
        off      = W_W'(bcnt_reg[endpoint]) + W_W'(dn);
        s_waddr  = BA_W'(W_W'(bhead_reg[endpoint]) + off);
        if (first_of_frame)
        begin
            if (!both_open)
                s_status = ST_CLOSED;
            else if (W_W'(frame_length) > eff_max)
                s_status = ST_LARGE;
            else if (need > eff_cap || scnt_reg[endpoint] >= SC_W'(FRAME_SLOTS))
                s_status = ST_FULL;
            if (s_status == ST_OK)
            begin
                s_clen = LEN_W'(frame_length);
                if (frame_length == '0)
                    s_commit = 1'b1;
                else
                begin
                    s_wr = 1'b1;
                    s_commit = (frame_length == FLEN_W'(1));
                end
            end
        end
        else if (!tx_act_reg || tx_end_reg != endpoint)
            s_status = ST_LARGE;
        else if (tx_ref_reg != ST_OK)
            s_status = tx_ref_reg;
        else
        begin
            s_wr = 1'b1;
            s_clen = LEN_W'(tx_len_reg);
            s_commit = (tx_done_reg + FLEN_W'(1) >= tx_len_reg);
        end
    end

    assign r_dir = ~endpoint;
    assign l_raw = rx_dir_reg ? lrd1_reg : lrd0_reg;
    always_comb
    begin
        r_len = l_raw;
        if (W_W'(r_len) > W_W'(MAX_FRAME_BYTES))
            r_len = LEN_W'(MAX_FRAME_BYTES);
        if (W_W'(r_len) > W_W'(bcnt_reg[rx_dir_reg]))
            r_len = LEN_W'(bcnt_reg[rx_dir_reg]);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept && op == OP_RECEIVE && scnt_reg[r_dir] != '0)
                    state_next = S_RX_LEN;
            S_RX_LEN:
                if (r_len > LEN_W'(1))
                    state_next = S_RX_STREAM;
                else
                    state_next = S_IDLE;
            S_RX_STREAM:
                if (rx_cnt_reg + LEN_W'(1) >= rx_len_reg)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (accept && op == OP_SEND && s_wr)
        begin
            if (s_dir)
                bmem1[s_waddr] <= data;
            else
                bmem0[s_waddr] <= data;
        end
        if (accept && op == OP_SEND && s_commit)
        begin
            if (s_dir)
                lmem1[SA_W'(shead_reg[1] + SA_W'(scnt_reg[1]))] <= s_clen;
            else
                lmem0[SA_W'(shead_reg[0] + SA_W'(scnt_reg[0]))] <= s_clen;
        end
        brd0_reg <= bmem0[rx_ptr_reg];
        brd1_reg <= bmem1[rx_ptr_reg];
        lrd0_reg <= lmem0[shead_reg[0]];
        lrd1_reg <= lmem1[shead_reg[1]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                bhead_reg[i] <= '0;
                bcnt_reg[i]  <= '0;
                shead_reg[i] <= '0;
                scnt_reg[i]  <= '0;
            end
            open_reg    <= 2'b11;
            maxf_reg    <= MAXF_W'(64);
            cap_reg     <= CAP_W'(1024);
            tx_act_reg  <= 1'b0;
            tx_end_reg  <= 1'b0;
            tx_len_reg  <= '0;
            tx_done_reg <= '0;
            tx_ref_reg  <= ST_OK;
            state_reg   <= S_IDLE;
            rx_dir_reg  <= 1'b0;
            rx_len_reg  <= '0;
            rx_cnt_reg  <= '0;
            rx_ptr_reg  <= '0;
            done_reg    <= 1'b0;
            status_reg  <= ST_OK;
            rxd_reg     <= '0;
            rxl_reg     <= '0;
            last_reg    <= 1'b0;
            pdir_reg    <= 1'b0;
            rxsel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            rxsel_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == REG_MAX_FRAME)
                    maxf_reg <= cfg_data[MAXF_W-1:0];
                else if (cfg_index == REG_CAPACITY)
                    cap_reg <= cfg_data[CAP_W-1:0];
            end
            if (accept)
            begin
                done_reg   <= (op != OP_RECEIVE) || scnt_reg[r_dir] == '0;
                rxd_reg    <= '0;
                rxl_reg    <= '0;
                last_reg   <= 1'b1;
                pdir_reg   <= r_dir;
                status_reg <= ST_OK;
                case (op_t'(op))
                    OP_SEND:
                    begin
                        status_reg <= s_status;
                        if (first_of_frame)
                        begin
                            tx_end_reg  <= endpoint;
                            tx_len_reg  <= frame_length;
                            tx_ref_reg  <= s_status;
                            tx_done_reg <= FLEN_W'(1);
                            tx_act_reg  <= (s_status != ST_OK) ? (frame_length > FLEN_W'(1))
                                                               : !s_commit;
                        end
                        else if (tx_act_reg && tx_end_reg == endpoint)
                        begin
                            tx_done_reg <= tx_done_reg + FLEN_W'(1);
                            if (tx_done_reg + FLEN_W'(1) >= tx_len_reg)
                                tx_act_reg <= 1'b0;
                        end
                        if (s_commit)
                        begin
                            scnt_reg[s_dir] <= scnt_reg[s_dir] + SC_W'(1);
                            bcnt_reg[s_dir] <= bcnt_reg[s_dir] + BC_W'(s_clen);
                        end
                    end
                    OP_RECEIVE:
                    begin
                        rx_dir_reg <= r_dir;
                        if (scnt_reg[r_dir] == '0)
                            status_reg <= both_open ? ST_EMPTY : ST_CLOSED;
                    end
                    OP_CLOSE:
                        open_reg[endpoint] <= 1'b0;
                    default:
                        status_reg <= ST_OK;
                endcase
            end
            if (state_reg == S_RX_LEN)
            begin
                rx_len_reg <= r_len;
                rx_cnt_reg <= '0;
                rx_ptr_reg <= bhead_reg[rx_dir_reg];
                shead_reg[rx_dir_reg] <= shead_reg[rx_dir_reg] + SA_W'(1);
                scnt_reg[rx_dir_reg]  <= scnt_reg[rx_dir_reg] - SC_W'(1);
                bhead_reg[rx_dir_reg] <= BA_W'(W_W'(bhead_reg[rx_dir_reg]) + W_W'(r_len));
                bcnt_reg[rx_dir_reg]  <= bcnt_reg[rx_dir_reg] - BC_W'(r_len);
                pdir_reg   <= rx_dir_reg;
                status_reg <= ST_OK;
                rxl_reg    <= r_len;
                rxd_reg    <= '0;
                if (r_len == '0)
                begin
                    done_reg <= 1'b1;
                    last_reg <= 1'b1;
                end
                else
                    rx_ptr_reg <= bhead_reg[rx_dir_reg];
            end
            if (state_reg == S_RX_LEN && r_len != '0)
            begin
                rx_ptr_reg <= bhead_reg[rx_dir_reg] + BA_W'(1);
                rx_cnt_reg <= LEN_W'(1);
            end
            if (state_reg == S_RX_STREAM || (state_reg == S_RX_LEN && r_len != '0))
            begin
                rxsel_reg <= 1'b1;
                done_reg  <= 1'b1;
                last_reg  <= (state_reg == S_RX_LEN) ? (r_len == LEN_W'(1))
                                                     : (rx_cnt_reg + LEN_W'(1) >= rx_len_reg);
                if (state_reg == S_RX_STREAM)
                begin
                    rx_cnt_reg <= rx_cnt_reg + LEN_W'(1);
                    rx_ptr_reg <= rx_ptr_reg + BA_W'(1);
                end
            end
        end
    end

    // first byte is read at the head pointer while in S_RX_LEN
    // so the byte register holds it when the first result is driven
    logic [DATA_W-1:0] first_byte_reg;
    always_ff @(posedge clk)
    begin
        first_byte_reg <= rx_dir_reg ? bmem1[bhead_reg[rx_dir_reg]]
                                     : bmem0[bhead_reg[rx_dir_reg]];
    end

    logic first_sel_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            first_sel_reg <= 1'b0;
        else
            first_sel_reg <= (state_reg == S_RX_LEN);
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign rx_data        = !rxsel_reg ? rxd_reg
                          : first_sel_reg ? first_byte_reg
                          : (rx_dir_reg ? brd1_reg : brd0_reg);
    assign rx_length      = rxl_reg;
    assign last           = last_reg;
    assign pending_frames = PFR_W'(scnt_reg[pdir_reg]);
    assign pending_bytes  = PBY_W'(bcnt_reg[pdir_reg]);
    assign channel_open   = both_open;

endmodule

// ----- rtl/dfm_checker.sv -----
module dfm_checker
    import dfm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic [OP_W-1:0]     op,
    input logic                done,
    input logic [STATUS_W-1:0] status,
    input logic                last,
    input logic [LEN_W-1:0]    rx_length,
    input logic                channel_open
);

    a_send_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op == OP_SEND |=> done && last)
        else $error("send without single result");

    a_close_shut: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op == OP_CLOSE |=> !channel_open)
        else $error("close left channel open");

    a_open_stays: assert property (@(posedge clk) disable iff (!rst_n)
        !channel_open |=> !channel_open)
        else $error("channel reopened");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status <= ST_LARGE)
        else $error("bad status");

    a_len_stable: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last && rx_length != '0 |=> done && $stable(rx_length))
        else $error("frame run broken");

endmodule

bind duplex_frame_mailbox dfm_checker u_dfm_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
    .done(done), .status(status), .last(last), .rx_length(rx_length),
    .channel_open(channel_open)
);

// ----- verif/duplex_frame_mailbox_tb.sv -----
`timescale 1ns / 100ps

module duplex_frame_mailbox_tb;
    import dfm_pkg::*;

    localparam int WDOG_LIMIT = 1000;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic                ep;
        logic                first;
        logic [FLEN_W-1:0]   len;
        logic [DATA_W-1:0]   data;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [DATA_W-1:0]   rxd;
        logic [LEN_W-1:0]    rxl;
        logic                lst;
        logic [PFR_W-1:0]    pf;
        logic [PBY_W-1:0]    pb;
        logic                copen;
    } reply_t;

    typedef struct packed {
        cmd_t   c;
        logic   chk;
        reply_t r;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [OP_W-1:0] op = OP_NONE;
    logic endpoint = 1'b0;
    logic first_of_frame = 1'b0;
    logic [FLEN_W-1:0] frame_length = '0;
    logic [DATA_W-1:0] data = '0;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic busy, done, last, channel_open;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0] rx_data;
    logic [LEN_W-1:0] rx_length;
    logic [PFR_W-1:0] pending_frames;
    logic [PBY_W-1:0] pending_bytes;

    duplex_frame_mailbox u_top (.*);

    always #6 clk = ~clk;

    // mailbox shadow state
    logic [7:0] mb_bytes [2][BUFFER_BYTES_DEF];
    logic [6:0] mb_lens  [2][FRAME_SLOTS_DEF];
    int unsigned bhead[2], bcnt[2], shead[2], scnt[2];
    bit ep_open[2] = '{1'b1, 1'b1};
    int unsigned max_frame_r = 64, capacity_r = 1024;
    bit tx_act;
    int unsigned tx_ep, tx_len, tx_cnt;
    logic [STATUS_W-1:0] tx_refuse;

    reply_t replies_due[$];
    int errors = 0;
    int wdog = 0;
    bit burst = 1'b0;

    function automatic bit both_open();
        return ep_open[0] && ep_open[1];
    endfunction

    function automatic void post(logic [2:0] st, int unsigned rxd, int unsigned rxl,
                                 bit lst, int unsigned inb);
        reply_t r;
        r.st = st; r.rxd = rxd[7:0]; r.rxl = rxl[6:0]; r.lst = lst;
        r.pf = scnt[inb][8:0]; r.pb = bcnt[inb][10:0]; r.copen = both_open();
        replies_due.push_back(r);
    endfunction

    function automatic void commit_frame(int unsigned d, int unsigned len);
        mb_lens[d][(shead[d] + scnt[d]) % FRAME_SLOTS_DEF] = len[6:0];
        scnt[d]++;
        bcnt[d] += len;
        tx_act = 0;
    endfunction

    function automatic void store_byte(int unsigned d, logic [7:0] b);
        mb_bytes[d][(bhead[d] + bcnt[d] + tx_cnt) % BUFFER_BYTES_DEF] = b;
        tx_cnt++;
    endfunction

    function automatic logic [2:0] send_step(cmd_t c);
        int unsigned d, emax, ecap;
        logic [2:0] code;
        d = c.ep;
        emax = max_frame_r < MAX_FRAME_BYTES_DEF ? max_frame_r : MAX_FRAME_BYTES_DEF;
        ecap = capacity_r < BUFFER_BYTES_DEF ? capacity_r : BUFFER_BYTES_DEF;
        if (c.first) begin
            code = ST_OK;
            tx_act = 0;
            if (!both_open()) code = ST_CLOSED;
            else if (c.len > emax) code = ST_LARGE;
            else if (bcnt[d] + c.len > ecap || scnt[d] >= FRAME_SLOTS_DEF) code = ST_FULL;
            tx_ep = c.ep; tx_len = c.len; tx_cnt = 0; tx_refuse = code;
            if (code != ST_OK) begin
                tx_cnt = 1;
                tx_act = c.len > 1;
                return code;
            end
            if (c.len == 0) begin
                commit_frame(d, 0);
                return ST_OK;
            end
            tx_act = 1;
            store_byte(d, c.data);
            if (tx_cnt >= tx_len) commit_frame(d, tx_len);
            return ST_OK;
        end
        if (!tx_act || tx_ep != c.ep) return ST_LARGE;
        if (tx_refuse != ST_OK) begin
            tx_cnt++;
            if (tx_cnt >= tx_len) tx_act = 0;
            return tx_refuse;
        end
        store_byte(d, c.data);
        if (tx_cnt >= tx_len) commit_frame(d, tx_len);
        return ST_OK;
    endfunction

    function automatic void predict_mailbox(cmd_t c);
        int unsigned d, len, s;
        logic [2:0] st;
        st = ST_OK;
        if (c.op == OP_RECEIVE) begin
            d = c.ep ^ 1;
            if (scnt[d] == 0) begin
                post(both_open() ? ST_EMPTY : ST_CLOSED, 0, 0, 1, d);
                return;
            end
            len = mb_lens[d][shead[d] % FRAME_SLOTS_DEF];
            if (len > MAX_FRAME_BYTES_DEF) len = MAX_FRAME_BYTES_DEF;
            if (len > bcnt[d]) len = bcnt[d];
            s = bhead[d];
            bhead[d] = (bhead[d] + len) % BUFFER_BYTES_DEF;
            bcnt[d] -= len;
            shead[d] = (shead[d] + 1) % FRAME_SLOTS_DEF;
            scnt[d]--;
            if (len == 0) begin
                post(ST_OK, 0, 0, 1, d);
                return;
            end
            for (int i = 0; i < len; i++)
                post(ST_OK, mb_bytes[d][(s + i) % BUFFER_BYTES_DEF], len, i + 1 == len, d);
            return;
        end
        if (c.op == OP_SEND) st = send_step(c);
        else if (c.op == OP_CLOSE) ep_open[c.ep] = 0;
        post(st, 0, 0, 1, c.ep ^ 1);
    endfunction

    task automatic issue(cmd_t c, bit chk = 0, reply_t typed = '0);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        repeat (gap) @(negedge clk) start <= 1'b0;
        @(negedge clk);
        start <= 1'b1;
        op <= c.op; endpoint <= c.ep; first_of_frame <= c.first;
        frame_length <= c.len; data <= c.data;
        do @(posedge clk); while (busy);
        predict_mailbox(c);
        if (chk) replies_due[replies_due.size() - 1] = typed;
    endtask

    task automatic drain();
        @(negedge clk) start <= 1'b0;
        wait (replies_due.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_regs(int unsigned mf, int unsigned cap);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= REG_MAX_FRAME; cfg_data <= CFG_W'(mf);
        @(negedge clk);
        cfg_index <= REG_CAPACITY; cfg_data <= CFG_W'(cap);
        @(negedge clk);
        cfg_we <= 1'b0;
        max_frame_r = mf & 'h7F;
        capacity_r = cap & 'h7FF;
    endtask

    function automatic cmd_t mk(logic [1:0] o, bit e, bit f, int unsigned l, int unsigned d);
        cmd_t c;
        c.op = o; c.ep = e; c.first = f; c.len = l[7:0]; c.data = d[7:0];
        return c;
    endfunction

    task automatic random_traffic(int n);
        int cnt, r, len, sent;
        bit e;
        cnt = 0;
        while (cnt < n) begin
            if (cnt % 40 == 0) burst = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            e = $urandom_range(0, 1);
            if (r < 55) begin
                r = $urandom_range(0, 99);
                if (r < 75) len = $urandom_range(0, 12);
                else if (r < 92) len = $urandom_range(13, 64);
                else len = $urandom_range(65, 255);
                sent = len > 64 ? $urandom_range(1, 6) : (len == 0 ? 1 : len);
                if ($urandom_range(0, 9) == 0) sent = $urandom_range(1, sent);
                for (int i = 0; i < sent; i++)
                    issue(mk(OP_SEND, e, i == 0, i == 0 ? len : $urandom_range(0, 255),
                             $urandom_range(0, 255)));
                cnt += sent;
            end else begin
                if (r < 85) issue(mk(OP_RECEIVE, e, $urandom_range(0, 1),
                                     $urandom_range(0, 255), $urandom_range(0, 255)));
                else if (r < 95) issue(mk(OP_SEND, e, 0, $urandom_range(0, 255),
                                          $urandom_range(0, 255)));
                else issue(mk(OP_NONE, e, $urandom_range(0, 1), $urandom_range(0, 255),
                              $urandom_range(0, 255)));
                cnt++;
            end
        end
    endtask

    always @(posedge clk) begin
        reply_t got, want;
        if (done) begin
            got = '{status, rx_data, rx_length, last, pending_frames, pending_bytes,
                    channel_open};
            if (replies_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected transaction: %p", got);
            end else begin
                want = replies_due[0];
                replies_due.delete(0);
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: exp %p got %p", want, got);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || done || (start && !busy)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    row_t open_rows [12];
    row_t close_rows [9];

    initial begin
        open_rows[0]  = '{mk(OP_RECEIVE, 0, 0, 0, 0), 1, '{ST_EMPTY, 0, 0, 1, 0, 0, 1}};
        open_rows[1]  = '{mk(OP_SEND, 0, 0, 0, 0), 1, '{ST_LARGE, 0, 0, 1, 0, 0, 1}};
        open_rows[2]  = '{mk(OP_SEND, 1, 1, 255, 255), 1, '{ST_LARGE, 0, 0, 1, 0, 0, 1}};
        open_rows[3]  = '{mk(OP_SEND, 1, 0, 0, 0), 0, '0};
        open_rows[4]  = '{mk(OP_SEND, 0, 1, 3, 8'h00), 0, '0};
        open_rows[5]  = '{mk(OP_SEND, 1, 0, 0, 8'h77), 0, '0};
        open_rows[6]  = '{mk(OP_SEND, 0, 0, 0, 8'hFF), 0, '0};
        open_rows[7]  = '{mk(OP_SEND, 0, 0, 0, 8'h5A), 0, '0};
        open_rows[8]  = '{mk(OP_SEND, 1, 1, 0, 8'hA5), 0, '0};
        open_rows[9]  = '{mk(OP_RECEIVE, 1, 0, 0, 0), 0, '0};
        open_rows[10] = '{mk(OP_RECEIVE, 0, 0, 0, 0), 0, '0};
        open_rows[11] = '{mk(OP_NONE, 1, 1, 255, 255), 0, '0};
        close_rows[0] = '{mk(OP_SEND, 0, 1, 4, 1), 0, '0};
        close_rows[1] = '{mk(OP_SEND, 0, 1, 2, 2), 0, '0};
        close_rows[2] = '{mk(OP_CLOSE, 1, 0, 0, 0), 0, '0};
        close_rows[3] = '{mk(OP_SEND, 0, 0, 0, 3), 0, '0};
        close_rows[4] = '{mk(OP_SEND, 1, 1, 3, 4), 0, '0};
        close_rows[5] = '{mk(OP_SEND, 1, 0, 0, 5), 0, '0};
        close_rows[6] = '{mk(OP_RECEIVE, 1, 0, 0, 0), 0, '0};
        close_rows[7] = '{mk(OP_RECEIVE, 1, 0, 0, 0), 0, '0};
        close_rows[8] = '{mk(OP_CLOSE, 0, 0, 0, 0), 0, '0};

        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (open_rows[i]) issue(open_rows[i].c, open_rows[i].chk, open_rows[i].r);
        for (int i = 0; i < 64; i++)
            issue(mk(OP_SEND, 1, i == 0, 64, $urandom_range(0, 255)));
        issue(mk(OP_RECEIVE, 0, 0, 0, 0));

        set_regs(8, 40);
        random_traffic(35);
        set_regs(0, 0);
        random_traffic(35);
        set_regs(127, 2047);
        random_traffic(35);
        set_regs(1, 3);
        random_traffic(35);
        set_regs(64, 1024);
        random_traffic(35);

        foreach (close_rows[i]) issue(close_rows[i].c, close_rows[i].chk, close_rows[i].r);
        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/dfm_pkg.sv
rtl/duplex_frame_mailbox.sv
rtl/dfm_checker.sv
verif/duplex_frame_mailbox_tb.sv
